[rtl/wrrts_pkg.sv]
// ----------------------------------------------------------------------------
// wrrts_pkg: weighted round robin task scheduler package
// Slot count, field widths, event codes and the controller command bundle.
// ----------------------------------------------------------------------------
package wrrts_pkg;

	// number of task slots and the bits of a slot index
	localparam int TASK_SLOTS = 4;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int SLOT_CW    = SLOT_W + 1;

	// fixed field widths
	localparam int ACTION_W = 3;
	localparam int ID_W     = 2;
	localparam int QUANT_W  = 4;
	localparam int SP_W     = 32;

	// decoded event codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK     = 3'd0,
		ACT_SWITCH   = 3'd1,
		ACT_EXIT     = 3'd2,
		ACT_ACTIVATE = 3'd3,
		ACT_SET_QNT  = 3'd4
	} action_t;

	// slot life cycle
	typedef enum logic [1:0] {
		ST_DORMANT = 2'd0,
		ST_READY   = 2'd1,
		ST_RUNNING = 2'd2
	} slot_state_t;

	// activation outcome
	typedef enum logic [1:0] {
		STAT_NONE      = 2'd0,
		STAT_ACTIVATED = 2'd1,
		STAT_ALREADY   = 2'd2
	} act_status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic commit;
	} dp_cmd_t;

endpackage

[rtl/wrrts_event_if.sv]
// ----------------------------------------------------------------------------
// wrrts_event_if: scheduler event channel
// Valid/ready channel carrying one decoded scheduler event.
// ----------------------------------------------------------------------------
interface wrrts_event_if
	import wrrts_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ID_W-1:0]     task_id;
	logic [QUANT_W-1:0]  quantum;
	logic [SP_W-1:0]     outgoing_sp;
	logic [SP_W-1:0]     initial_sp;

	modport source (
		output valid, action, task_id, quantum, outgoing_sp, initial_sp,
		input  ready
	);
	modport sink (
		input  valid, action, task_id, quantum, outgoing_sp, initial_sp,
		output ready
	);
endinterface

[rtl/wrrts_result_if.sv]
// ----------------------------------------------------------------------------
// wrrts_result_if: scheduler result channel
// Valid/ready channel carrying the outcome of one scheduler event.
// ----------------------------------------------------------------------------
interface wrrts_result_if
	import wrrts_pkg::*;
();
	logic            valid;
	logic            ready;
	logic            switch_request;
	logic [SP_W-1:0] next_sp;
	logic [1:0]      running_index;
	logic            running_valid;
	logic            found_ready;
	logic [1:0]      activation_status;

	modport source (
		output valid, switch_request, next_sp, running_index, running_valid,
		       found_ready, activation_status,
		input  ready
	);
	modport sink (
		input  valid, switch_request, next_sp, running_index, running_valid,
		       found_ready, activation_status,
		output ready
	);
endinterface

[rtl/wrrts_ctrl.sv]
// ----------------------------------------------------------------------------
// wrrts_ctrl: scheduler controller
// Sequences capture and execution of one event and owns the result valid.
// ----------------------------------------------------------------------------
module wrrts_ctrl
	import wrrts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        out_free;

	// result register can take a new value this cycle
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a commit never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten while stalled");

	// a result appears only after a commit
	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result valid without commit");

	// a captured request is executed next
	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC))
		else $error("captured request not executed");

endmodule

[rtl/wrrts_dp.sv]
// ----------------------------------------------------------------------------
// wrrts_dp: scheduler datapath
// Slot tables, current task, round robin search and the result register.
// ----------------------------------------------------------------------------
module wrrts_dp
	import wrrts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [ACTION_W-1:0] action,
	input  logic [ID_W-1:0]     task_id,
	input  logic [QUANT_W-1:0]  quantum,
	input  logic [SP_W-1:0]     outgoing_sp,
	input  logic [SP_W-1:0]     initial_sp,
	output logic                switch_request,
	output logic [SP_W-1:0]     next_sp,
	output logic [1:0]          running_index,
	output logic                running_valid,
	output logic                found_ready,
	output logic [1:0]          activation_status
);

	// captured request
	logic [ACTION_W-1:0] action_q;
	logic [ID_W-1:0]     task_id_q;
	logic [QUANT_W-1:0]  nq_q;
	logic [SP_W-1:0]     osp_q;
	logic [SP_W-1:0]     isp_q;

	// slot tables and current task
	slot_state_t        state_q [TASK_SLOTS];
	logic [QUANT_W-1:0] quant_q [TASK_SLOTS];
	logic [QUANT_W-1:0] rem_q   [TASK_SLOTS];
	logic [SP_W-1:0]    sp_q    [TASK_SLOTS];
	logic               cur_valid_q;
	logic [SLOT_W-1:0]  cur_idx_q;

	// next values
	slot_state_t        state_nxt [TASK_SLOTS];
	logic [QUANT_W-1:0] quant_nxt [TASK_SLOTS];
	logic [QUANT_W-1:0] rem_nxt   [TASK_SLOTS];
	logic [SP_W-1:0]    sp_nxt    [TASK_SLOTS];
	logic               cur_valid_nxt;
	logic [SLOT_W-1:0]  cur_idx_nxt;

	// result register
	logic              req_q;
	logic [SP_W-1:0]   nsp_q;
	logic [1:0]        ridx_q;
	logic              rvalid_q;
	logic              found_q;
	act_status_t       stat_q;

	// per-event results
	logic              req_c;
	logic [SP_W-1:0]   nsp_c;
	logic              found_c;
	act_status_t       stat_c;

	// helpers
	logic              cur_run;
	logic              id_ok;
	logic [SLOT_W-1:0] slot_id;
	logic [SLOT_W-1:0] start;
	logic [SLOT_CW-1:0] pos;
	slot_state_t       st_sw [TASK_SLOTS];
	logic              hit;
	logic [SLOT_W-1:0] cand;

	assign cur_run = cur_valid_q && (state_q[cur_idx_q] == ST_RUNNING);
	assign id_ok   = (32'(task_id_q) < TASK_SLOTS);
	assign slot_id = SLOT_W'(task_id_q);
	assign start   = !cur_valid_q ? '0 :
	                 (cur_idx_q == SLOT_W'(TASK_SLOTS - 1)) ? '0 : cur_idx_q + 1'b1;

	// slot states as seen by the switch search: running slot parked first
	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			st_sw[i] = state_q[i];
		end
		if (cur_run) begin
			st_sw[cur_idx_q] = ST_READY;
		end
	end

	// round robin search, current slot visited last
	always_comb begin
		hit  = 1'b0;
		cand = '0;
		pos  = '0;
		for (int k = TASK_SLOTS - 1; k >= 0; k--) begin
			pos = {1'b0, start} + SLOT_CW'(k);
			if (pos >= SLOT_CW'(TASK_SLOTS)) begin
				pos = pos - SLOT_CW'(TASK_SLOTS);
			end
			if (st_sw[pos[SLOT_W-1:0]] == ST_READY) begin
				hit  = 1'b1;
				cand = pos[SLOT_W-1:0];
			end
		end
	end

	// event execution
	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			state_nxt[i] = state_q[i];
			quant_nxt[i] = quant_q[i];
			rem_nxt[i]   = rem_q[i];
			sp_nxt[i]    = sp_q[i];
		end
		cur_valid_nxt = cur_valid_q;
		cur_idx_nxt   = cur_idx_q;
		req_c   = 1'b0;
		nsp_c   = '0;
		found_c = 1'b0;
		stat_c  = STAT_NONE;
		case (action_q)
			ACT_TICK: begin
				if (cur_run) begin
					if (rem_q[cur_idx_q] > QUANT_W'(1)) begin
						rem_nxt[cur_idx_q] = rem_q[cur_idx_q] - 1'b1;
					end else begin
						rem_nxt[cur_idx_q] = quant_q[cur_idx_q];
						req_c = 1'b1;
					end
				end else begin
					req_c = 1'b1;
				end
			end
			ACT_SWITCH: begin
				for (int i = 0; i < TASK_SLOTS; i++) begin
					state_nxt[i] = st_sw[i];
				end
				if (cur_run) begin
					sp_nxt[cur_idx_q] = osp_q;
				end
				if (hit) begin
					cur_valid_nxt   = 1'b1;
					cur_idx_nxt     = cand;
					state_nxt[cand] = ST_RUNNING;
					rem_nxt[cand]   = quant_q[cand];
					nsp_c   = (cur_run && cand == cur_idx_q) ? osp_q : sp_q[cand];
					found_c = 1'b1;
				end else begin
					nsp_c = osp_q;
				end
			end
			ACT_EXIT: begin
				if (cur_valid_q) begin
					state_nxt[cur_idx_q] = ST_DORMANT;
					req_c = 1'b1;
				end
			end
			ACT_ACTIVATE: begin
				if (id_ok) begin
					if (state_q[slot_id] == ST_DORMANT) begin
						sp_nxt[slot_id]    = isp_q;
						state_nxt[slot_id] = ST_READY;
						rem_nxt[slot_id]   = quant_q[slot_id];
						stat_c = STAT_ACTIVATED;
					end else begin
						stat_c = STAT_ALREADY;
					end
				end
			end
			ACT_SET_QNT: begin
				if (id_ok && nq_q != '0) begin
					quant_nxt[slot_id] = nq_q;
					if (state_q[slot_id] == ST_RUNNING) begin
						rem_nxt[slot_id] = nq_q;
					end
				end
			end
			default: ;
		endcase
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= action;
			task_id_q <= task_id;
			nq_q      <= quantum;
			osp_q     <= outgoing_sp;
			isp_q     <= initial_sp;
		end
		if (cmd.commit) begin
			req_q    <= req_c;
			nsp_q    <= nsp_c;
			ridx_q   <= 2'(cur_idx_nxt);
			rvalid_q <= cur_valid_nxt;
			found_q  <= found_c;
			stat_q   <= stat_c;
		end
	end

	// saved stack pointers, no reset
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				sp_q[i] <= sp_nxt[i];
			end
		end
	end

	// slot control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				state_q[i] <= ST_DORMANT;
				quant_q[i] <= QUANT_W'(1);
				rem_q[i]   <= QUANT_W'(1);
			end
			cur_valid_q <= 1'b0;
			cur_idx_q   <= '0;
		end else if (cmd.commit) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				state_q[i] <= state_nxt[i];
				quant_q[i] <= quant_nxt[i];
				rem_q[i]   <= rem_nxt[i];
			end
			cur_valid_q <= cur_valid_nxt;
			cur_idx_q   <= cur_idx_nxt;
		end
	end

	assign switch_request    = req_q;
	assign next_sp           = nsp_q;
	assign running_index     = ridx_q;
	assign running_valid     = rvalid_q;
	assign found_ready       = found_q;
	assign activation_status = stat_q;

	// at most one slot is ever running
	a_one_running: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({state_q[0] == ST_RUNNING, state_q[1] == ST_RUNNING,
		            state_q[2] == ST_RUNNING, state_q[3] == ST_RUNNING}) <= 1)
		else $error("more than one running slot");

	// a found switch leaves the chosen slot running
	a_found_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && action_q == ACT_SWITCH && hit) |=>
		(cur_valid_q && state_q[cur_idx_q] == ST_RUNNING))
		else $error("switch did not start chosen slot");

	// remaining ticks of the search candidate never drop to zero on a commit
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (rem_nxt[cand] != '0))
		else $error("remaining ticks reached zero");

endmodule

[rtl/weighted_round_robin_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// weighted_round_robin_task_scheduler_top: weighted round robin scheduler
// Four task slots with quantum weights, driven by decoded events.
// ----------------------------------------------------------------------------
// Usage: events enter on task_event (tick, switch, exit, activate, set
// quantum) and each yields exactly one result on sched_result carrying the
// switch request, the pointer to resume, the current task and status.
// An event is captured at the edge that accepts it and executed in the
// execute step that follows, which commits its result to the result
// register once that register is free.
// The controller alternates capture and execute steps, so a new event is
// not accepted until the last one is committed; the round robin search
// over the slots is combinational and completes within the execute step.
// A new event can be accepted while a result still waits; if the receiver
// stalls, that event is held in the execute step until the result is taken.
// Reset: all slots dormant with quantum and remaining ticks of one, no
// current task, no result pending. Saved stack pointers are not cleared;
// a slot's pointer is only read after an activate or switch writes it.
// ----------------------------------------------------------------------------
module weighted_round_robin_task_scheduler_top
	import wrrts_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	wrrts_event_if.sink   task_event,
	wrrts_result_if.source sched_result
);

	dp_cmd_t cmd;

	// sequencing
	wrrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (task_event.valid),
		.in_ready  (task_event.ready),
		.out_valid (sched_result.valid),
		.out_ready (sched_result.ready),
		.cmd       (cmd)
	);

	// slot tables and result
	wrrts_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.action            (task_event.action),
		.task_id           (task_event.task_id),
		.quantum           (task_event.quantum),
		.outgoing_sp       (task_event.outgoing_sp),
		.initial_sp        (task_event.initial_sp),
		.switch_request    (sched_result.switch_request),
		.next_sp           (sched_result.next_sp),
		.running_index     (sched_result.running_index),
		.running_valid     (sched_result.running_valid),
		.found_ready       (sched_result.found_ready),
		.activation_status (sched_result.activation_status)
	);

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: weighted round robin task scheduler testbench
// Sends decoded scheduler events over the valid/ready event channel. A
// directed table comes first, then weighted random events. Every result is
// checked against the table's expectation or a cycle-free slot table model
// kept in this file. Both channels idle at random, and the result side
// stalls once for a long stretch so that the scheduler backs up.
// ----------------------------------------------------------------------------
module tb;
	import wrrts_pkg::*;

	// reserved event codes, which the scheduler must ignore
	localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

	localparam int RANDOM_EVENTS = 900;
	localparam int HOLD_CYCLES   = 80;
	localparam int IDLE_PCT      = 18;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     task_id;
		logic [QUANT_W-1:0]  quantum;
		logic [SP_W-1:0]     outgoing_sp;
		logic [SP_W-1:0]     initial_sp;
	} sched_event_t;

	typedef struct packed {
		logic            switch_request;
		logic [SP_W-1:0] next_sp;
		logic [1:0]      running_index;
		logic            running_valid;
		logic            found_ready;
		act_status_t     activation_status;
	} sched_outcome_t;

	typedef struct {
		sched_event_t   ev;
		bit             typed;
		sched_outcome_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	wrrts_event_if  ev_ch();
	wrrts_result_if res_ch();

	weighted_round_robin_task_scheduler_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.task_event   (ev_ch),
		.sched_result (res_ch)
	);

	// shadow slot table
	slot_state_t      slot_st    [TASK_SLOTS];
	logic [QUANT_W-1:0] slot_weight[TASK_SLOTS];
	logic [QUANT_W-1:0] slot_left  [TASK_SLOTS];
	logic [SP_W-1:0]  slot_sp    [TASK_SLOTS];
	bit               have_cur;
	logic [SLOT_W-1:0] cur_slot;

	sched_outcome_t outcome_q[$];

	bit idle_on;
	int hold_asks;
	int n_events;
	int n_checked;
	int n_errors;
	int n_hits;
	int n_expired;
	int n_activated;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("tb: FAIL");
		$finish;
	end

	// fresh slot table, as after reset
	function automatic void clear_slots();
		for (int i = 0; i < TASK_SLOTS; i++) begin
			slot_st[i]     = ST_DORMANT;
			slot_weight[i] = 4'd1;
			slot_left[i]   = 4'd1;
			slot_sp[i]     = '0;
		end
		have_cur = 1'b0;
		cur_slot = '0;
	endfunction

	// apply one event to the slot table and return its outcome
	function automatic sched_outcome_t schedule_event(sched_event_t e);
		sched_outcome_t o;
		int             first;
		int             s;
		int             pick;
		bit             hit;
		bit             running;
		o        = '0;
		pick     = 0;
		hit      = 1'b0;
		running  = have_cur && slot_st[cur_slot] == ST_RUNNING;
		case (e.action)
			ACT_TICK: begin
				if (!running) begin
					o.switch_request = 1'b1;
				end else if (slot_left[cur_slot] > 1) begin
					slot_left[cur_slot] = slot_left[cur_slot] - 1'b1;
				end else begin
					slot_left[cur_slot] = slot_weight[cur_slot];
					o.switch_request    = 1'b1;
					n_expired++;
				end
			end
			ACT_SWITCH: begin
				if (running) begin
					slot_sp[cur_slot] = e.outgoing_sp;
					slot_st[cur_slot] = ST_READY;
				end
				first = have_cur ? (int'(cur_slot) + 1) % TASK_SLOTS : 0;
				for (int k = 0; k < TASK_SLOTS; k++) begin
					s = (first + k) % TASK_SLOTS;
					if (!hit && slot_st[s] == ST_READY) begin
						pick = s;
						hit  = 1'b1;
					end
				end
				if (hit) begin
					have_cur        = 1'b1;
					cur_slot        = pick[SLOT_W-1:0];
					slot_st[pick]   = ST_RUNNING;
					slot_left[pick] = slot_weight[pick];
					o.next_sp       = slot_sp[pick];
					o.found_ready   = 1'b1;
					n_hits++;
				end else begin
					o.next_sp = e.outgoing_sp;
				end
			end
			ACT_EXIT: begin
				if (have_cur) begin
					slot_st[cur_slot] = ST_DORMANT;
					o.switch_request  = 1'b1;
				end
			end
			ACT_ACTIVATE: begin
				if (slot_st[e.task_id] == ST_DORMANT) begin
					slot_sp[e.task_id]   = e.initial_sp;
					slot_st[e.task_id]   = ST_READY;
					slot_left[e.task_id] = slot_weight[e.task_id];
					o.activation_status  = STAT_ACTIVATED;
					n_activated++;
				end else begin
					o.activation_status = STAT_ALREADY;
				end
			end
			ACT_SET_QNT: begin
				if (e.quantum != '0) begin
					slot_weight[e.task_id] = e.quantum;
					if (slot_st[e.task_id] == ST_RUNNING)
						slot_left[e.task_id] = e.quantum;
				end
			end
			default: begin
			end
		endcase
		o.running_index = cur_slot;
		o.running_valid = have_cur;
		return o;
	endfunction

	function automatic sched_event_t mk_event(logic [ACTION_W-1:0] a, logic [ID_W-1:0] id,
		logic [QUANT_W-1:0] q, logic [SP_W-1:0] osp, logic [SP_W-1:0] isp);
		sched_event_t e;
		e.action      = a;
		e.task_id     = id;
		e.quantum     = q;
		e.outgoing_sp = osp;
		e.initial_sp  = isp;
		return e;
	endfunction

	function automatic sched_outcome_t mk_outcome(logic req, logic [SP_W-1:0] nsp,
		logic [1:0] idx, logic rv, logic fnd, act_status_t st);
		sched_outcome_t o;
		o.switch_request    = req;
		o.next_sp           = nsp;
		o.running_index     = idx;
		o.running_valid     = rv;
		o.found_ready       = fnd;
		o.activation_status = st;
		return o;
	endfunction

	// weighted random event, mostly well-formed scheduling traffic
	function automatic sched_event_t random_event();
		sched_event_t e;
		int           pick;
		pick          = $urandom_range(99);
		e.task_id     = ID_W'($urandom_range(3));
		e.quantum     = ($urandom_range(9) < 7) ? QUANT_W'($urandom_range(3))
			: QUANT_W'($urandom_range(15));
		e.outgoing_sp = $urandom;
		e.initial_sp  = $urandom;
		if (pick < 34)
			e.action = ACT_TICK;
		else if (pick < 56)
			e.action = ACT_SWITCH;
		else if (pick < 63)
			e.action = ACT_EXIT;
		else if (pick < 83)
			e.action = ACT_ACTIVATE;
		else if (pick < 95)
			e.action = ACT_SET_QNT;
		else
			e.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
		return e;
	endfunction

	// offer one event until the scheduler takes it; returns once accepted
	task automatic offer_event(input sched_event_t e);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			ev_ch.valid <= 1'b0;
			@(posedge clk);
		end
		ev_ch.valid       <= 1'b1;
		ev_ch.action      <= e.action;
		ev_ch.task_id     <= e.task_id;
		ev_ch.quantum     <= e.quantum;
		ev_ch.outgoing_sp <= e.outgoing_sp;
		ev_ch.initial_sp  <= e.initial_sp;
		do
			@(posedge clk);
		while (ev_ch.ready !== 1'b1);
		n_events++;
	endtask

	// main stimulus
	initial begin
		dir_row_t       dir_tab[$];
		sched_outcome_t predicted;
		sched_event_t   e;

		arst_n             = 1'b0;
		ev_ch.valid        <= 1'b0;
		ev_ch.action       <= ACT_TICK;
		ev_ch.task_id      <= '0;
		ev_ch.quantum      <= '0;
		ev_ch.outgoing_sp  <= '0;
		ev_ch.initial_sp   <= '0;
		idle_on            = 1'b1;
		hold_asks          = 0;
		n_events           = 0;
		n_checked          = 0;
		n_errors           = 0;
		n_hits             = 0;
		n_expired          = 0;
		n_activated        = 0;
		clear_slots();

		// directed table
		dir_tab.push_back('{mk_event(ACT_TICK, 2'd0, 4'd0, 32'h0, 32'h0), 1'b1,
			mk_outcome(1'b1, 32'h0, 2'd0, 1'b0, 1'b0, STAT_NONE)});
		dir_tab.push_back('{mk_event(ACT_SWITCH, 2'd0, 4'd0, 32'hFFFF_FFFF, 32'h0), 1'b1,
			mk_outcome(1'b0, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, STAT_NONE)});
		dir_tab.push_back('{mk_event(ACT_EXIT, 2'd3, 4'd15, 32'h0, 32'h0), 1'b1,
			mk_outcome(1'b0, 32'h0, 2'd0, 1'b0, 1'b0, STAT_NONE)});
		dir_tab.push_back('{mk_event(ACT_ACTIVATE, 2'd0, 4'd0, 32'h0, 32'h0), 1'b1,
			mk_outcome(1'b0, 32'h0, 2'd0, 1'b0, 1'b0, STAT_ACTIVATED)});
		dir_tab.push_back('{mk_event(ACT_ACTIVATE, 2'd0, 4'd0, 32'h0, 32'h1234_5678), 1'b1,
			mk_outcome(1'b0, 32'h0, 2'd0, 1'b0, 1'b0, STAT_ALREADY)});
		dir_tab.push_back('{mk_event(ACT_ACTIVATE, 2'd3, 4'd0, 32'h0, 32'hFFFF_FFFF), 1'b1,
			mk_outcome(1'b0, 32'h0, 2'd0, 1'b0, 1'b0, STAT_ACTIVATED)});
		dir_tab.push_back('{mk_event(ACT_SET_QNT, 2'd0, 4'd15, 32'h0, 32'h0), 1'b1,
			mk_outcome(1'b0, 32'h0, 2'd0, 1'b0, 1'b0, STAT_NONE)});
		// zero weight is ignored
		dir_tab.push_back('{mk_event(ACT_SET_QNT, 2'd1, 4'd0, 32'h0, 32'h0), 1'b0, '0});
		// first switch starts the search at slot zero
		dir_tab.push_back('{mk_event(ACT_SWITCH, 2'd0, 4'd0, 32'h0, 32'h0), 1'b1,
			mk_outcome(1'b0, 32'h0, 2'd0, 1'b1, 1'b1, STAT_NONE)});
		dir_tab.push_back('{mk_event(ACT_TICK, 2'd0, 4'd0, 32'h0, 32'h0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_TICK, 2'd0, 4'd0, 32'h0, 32'h0), 1'b0, '0});
		// new weight on the running slot reloads its ticks
		dir_tab.push_back('{mk_event(ACT_SET_QNT, 2'd0, 4'd2, 32'h0, 32'h0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_TICK, 2'd0, 4'd0, 32'h0, 32'h0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_TICK, 2'd0, 4'd0, 32'h0, 32'h0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_SWITCH, 2'd0, 4'd0, 32'hA5A5_A5A5, 32'h0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_SET_QNT, 2'd3, 4'd1, 32'h0, 32'h0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_TICK, 2'd0, 4'd0, 32'h0, 32'h0), 1'b0, '0});
		// exit leaves the current index on a dormant slot
		dir_tab.push_back('{mk_event(ACT_EXIT, 2'd0, 4'd0, 32'h0, 32'h0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_TICK, 2'd0, 4'd0, 32'h0, 32'h0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_SWITCH, 2'd0, 4'd0, 32'h5A5A_5A5A, 32'h0), 1'b0, '0});
		// reserved codes with busy fields
		dir_tab.push_back('{mk_event(ACT_UNUSED_LO, 2'd3, 4'd15, 32'hFFFF_FFFF,
			32'hFFFF_FFFF), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_UNUSED_HI, 2'd2, 4'd9, 32'h1, 32'h2), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_ACTIVATE, 2'd1, 4'd0, 32'h0, 32'h0F0F_0F0F), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_ACTIVATE, 2'd2, 4'd0, 32'h0, 32'hF0F0_F0F0), 1'b0, '0});
		dir_tab.push_back('{mk_event(ACT_SWITCH, 2'd0, 4'd0, 32'h8000_0001, 32'h0), 1'b0, '0});

		// hold reset, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (dir_tab[i]) begin
			offer_event(dir_tab[i].ev);
			predicted = schedule_event(dir_tab[i].ev);
			outcome_q.push_back(dir_tab[i].typed ? dir_tab[i].want : predicted);
		end

		// random part with one long result stall and a stretch without gaps
		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			if (i == 300)
				hold_asks++;
			idle_on = !(i >= 500 && i < 650);
			e = random_event();
			offer_event(e);
			outcome_q.push_back(schedule_event(e));
		end
		ev_ch.valid <= 1'b0;
		idle_on = 1'b1;

		// drain and watch for stray results
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("tb: %0d events sent, %0d results checked, %0d mismatches", n_events,
			n_checked, n_errors);
		$display("tb: %0d switches to a ready task, %0d quanta spent, %0d activations",
			n_hits, n_expired, n_activated);
		if (n_errors == 0 && outcome_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// result side ready, with random gaps and one long hold
	initial begin
		int hold_done;
		int hold_left;
		hold_done = 0;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_asks != hold_done) begin
				hold_done++;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// compare each accepted result with the oldest expected outcome
	always @(posedge clk) begin
		sched_outcome_t got;
		sched_outcome_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.switch_request    = res_ch.switch_request;
			got.next_sp           = res_ch.next_sp;
			got.running_index     = res_ch.running_index;
			got.running_valid     = res_ch.running_valid;
			got.found_ready       = res_ch.found_ready;
			got.activation_status = act_status_t'(res_ch.activation_status);
			if (outcome_q.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("tb: unexpected result req=%b sp=%h idx=%0d rv=%b fnd=%b st=%0d",
						got.switch_request, got.next_sp, got.running_index,
						got.running_valid, got.found_ready, got.activation_status);
			end else begin
				want = outcome_q.pop_front();
				n_checked++;
				if (got.switch_request !== want.switch_request ||
					got.next_sp !== want.next_sp ||
					got.running_index !== want.running_index ||
					got.running_valid !== want.running_valid ||
					got.found_ready !== want.found_ready ||
					got.activation_status !== want.activation_status) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS) begin
						$display("tb: result %0d exp req=%b sp=%h idx=%0d rv=%b fnd=%b st=%0d",
							n_checked, want.switch_request, want.next_sp,
							want.running_index, want.running_valid, want.found_ready,
							want.activation_status);
						$display("tb: result %0d got req=%b sp=%h idx=%0d rv=%b fnd=%b st=%0d",
							n_checked, got.switch_request, got.next_sp, got.running_index,
							got.running_valid, got.found_ready, got.activation_status);
					end
				end
			end
		end
	end

endmodule
